>>> rtl/core/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types, widths and helpers of the projection hash block.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int DIM_W      = 11;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int WIN_W      = 31;
  localparam int FRAC_W     = 16;
  localparam int HASH_SCALE = 100;
  localparam int SCALE_W    = 7;
  localparam int PADDR_W    = 4;

  // coordinate count saturates at MAX_DIM + 1
  localparam int CNT_W = $clog2(MAX_DIM + 2);
  localparam int CMP_W = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;

  // scaled magnitude (|s| * 100) >> 16 feeds a restoring divider
  localparam int NUM_W     = ACC_W + SCALE_W - FRAC_W;
  localparam int STEP_W    = $clog2(NUM_W);
  localparam int QUO_W     = DATA_W + 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int QSUM_W  = QCNT_W + 1;

  typedef enum logic [1:0] {
    REG_DIMENSION = 2'd0,
    REG_OFFSET    = 2'd1,
    REG_WINDOW    = 2'd2
  } reg_addr_e;

  // finished point sum handed from the front to the back
  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             clamp;
    logic             cerr;
  } pt_word_t;

  // {overflow, saturated 64-bit signed sum}
  function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] a,
                                             input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    logic [ACC_W:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
    end else begin
      r = {1'b0, s[ACC_W-1:0]};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/lph_front.sv
// ----------------------------------------------------------------------------
// lph_front
// Takes coordinate/weight words, multiplies and accumulates the dot product,
// and pushes one finished sum per point into the queue.
// ----------------------------------------------------------------------------
module lph_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [lph_pkg::DATA_W-1:0] coordinate_i,
  input  logic signed [lph_pkg::DATA_W-1:0] weight_i,
  input  logic                          last_i,
  input  logic [lph_pkg::DIM_W-1:0]     dimension_i,
  input  logic [lph_pkg::QCNT_W-1:0]    q_count_i,
  output logic                          q_push_o,
  output lph_pkg::pt_word_t             q_word_o
);

  logic signed [lph_pkg::ACC_W-1:0] prod_d;
  logic [lph_pkg::ACC_W-1:0]        prod_q;
  logic                             prod_vld_q;
  logic                             prod_last_q;
  logic [lph_pkg::ACC_W-1:0]        acc_q, acc_d;
  logic [lph_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                             clamp_q, clamp_d;
  logic [lph_pkg::ACC_W:0]          add_res;
  logic [lph_pkg::ACC_W-1:0]        sum_n;
  logic [lph_pkg::CNT_W-1:0]        cnt_n;
  logic                             clamp_n;
  logic                             pend;
  logic                             accept;

  assign prod_d = coordinate_i * weight_i;

  // a point that ends in the product stage pushes this cycle; keep room for
  // one more so a word accepted now can always push next cycle
  assign pend       = prod_vld_q & prod_last_q;
  assign in_ready_o = (lph_pkg::QSUM_W'(q_count_i) + lph_pkg::QSUM_W'(pend))
                      < lph_pkg::QSUM_W'(lph_pkg::QDEPTH);
  assign accept     = in_valid_i & in_ready_o;

  assign add_res = lph_pkg::sat_add(acc_q, prod_q);
  assign sum_n   = add_res[lph_pkg::ACC_W-1:0];
  assign clamp_n = clamp_q | add_res[lph_pkg::ACC_W];
  assign cnt_n   = (cnt_q <= lph_pkg::CNT_W'(lph_pkg::MAX_DIM)) ? cnt_q + 1'b1 : cnt_q;

  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    clamp_d = clamp_q;
    if (prod_vld_q) begin
      if (prod_last_q) begin
        acc_d   = '0;
        cnt_d   = '0;
        clamp_d = 1'b0;
      end else begin
        acc_d   = sum_n;
        cnt_d   = cnt_n;
        clamp_d = clamp_n;
      end
    end
  end

  assign q_push_o       = pend;
  assign q_word_o.sum   = sum_n;
  assign q_word_o.clamp = clamp_n;
  assign q_word_o.cerr  =
      (lph_pkg::CMP_W'(dimension_i) > lph_pkg::CMP_W'(lph_pkg::MAX_DIM)) ||
      (lph_pkg::CMP_W'(cnt_n) != lph_pkg::CMP_W'(dimension_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      prod_q      <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      clamp_q     <= 1'b0;
    end else begin
      prod_vld_q <= accept;
      if (accept) begin
        prod_q      <= prod_d;
        prod_last_q <= last_i;
      end
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      clamp_q <= clamp_d;
    end
  end

endmodule

>>> rtl/core/lph_queue.sv
// ----------------------------------------------------------------------------
// lph_queue
// Short queue of finished point sums between the front and the back.
// ----------------------------------------------------------------------------
module lph_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  lph_pkg::pt_word_t          word_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output lph_pkg::pt_word_t          word_o,
  output logic [lph_pkg::QCNT_W-1:0] count_o
);

  lph_pkg::pt_word_t               mem_q [lph_pkg::QDEPTH];
  logic [lph_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [lph_pkg::QCNT_W-1:0]      cnt_q;

  function automatic logic [lph_pkg::QPTR_W-1:0] ptr_inc(
      input logic [lph_pkg::QPTR_W-1:0] p);
    logic [lph_pkg::QPTR_W-1:0] n;
    n = (p == lph_pkg::QPTR_W'(lph_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

endmodule

>>> rtl/core/lph_back.sv
// ----------------------------------------------------------------------------
// lph_back
// Adds the offset, scales by 100 and divides by the window one quotient bit
// per cycle, then saturates and holds the result word for the output side.
// ----------------------------------------------------------------------------
module lph_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  lph_pkg::pt_word_t                 q_word_i,
  output logic                              q_pop_o,
  input  logic signed [lph_pkg::DATA_W-1:0] offset_i,
  input  logic [lph_pkg::WIN_W-1:0]         window_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lph_pkg::DATA_W-1:0] hash_value_o,
  output logic                              saturated_o,
  output logic                              count_error_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFS,
    ST_MAG,
    ST_SCALE,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                        state_q;
  logic [lph_pkg::ACC_W-1:0]     s_q;
  logic                          clamp_q;
  logic                          cerr_q;
  logic                          neg_q;
  logic [lph_pkg::ACC_W-1:0]     mag_q;
  logic [lph_pkg::NUM_W-1:0]     num_q;
  logic [lph_pkg::WIN_W-1:0]     rem_q;
  logic [lph_pkg::QUO_W-1:0]     quo_q;
  logic                          big_q;
  logic [lph_pkg::STEP_W-1:0]    step_q;
  logic                          out_vld_q;
  logic [lph_pkg::DATA_W-1:0]    hash_q;
  logic                          sat_q;
  logic                          cerr_out_q;

  logic [lph_pkg::ACC_W-1:0]     offs_ext;
  logic [lph_pkg::ACC_W:0]       offs_res;
  logic [lph_pkg::ACC_W+lph_pkg::SCALE_W-1:0] scaled;
  logic [lph_pkg::WIN_W-1:0]     wdiv;
  logic [lph_pkg::WIN_W:0]       partial;
  logic [lph_pkg::WIN_W+1:0]     diff;
  logic                          qbit;
  logic [lph_pkg::WIN_W-1:0]     rem_n;
  logic [lph_pkg::QUO_W-1:0]     lim;
  logic                          over;
  logic [lph_pkg::DATA_W-1:0]    mag_fin;
  logic                          out_free;

  // offset is Q16.16, the sum Q32.32
  assign offs_ext = {{(lph_pkg::ACC_W-lph_pkg::DATA_W-lph_pkg::FRAC_W){offset_i[lph_pkg::DATA_W-1]}},
                     offset_i, {lph_pkg::FRAC_W{1'b0}}};
  assign offs_res = lph_pkg::sat_add(s_q, offs_ext);

  assign scaled = (lph_pkg::ACC_W+lph_pkg::SCALE_W)'(mag_q) *
                  (lph_pkg::ACC_W+lph_pkg::SCALE_W)'(lph_pkg::HASH_SCALE);

  // floor(m*100 / (w<<16)) == floor(((m*100)>>16) / w)
  assign wdiv    = (window_i == '0) ? lph_pkg::WIN_W'(1) : window_i;
  assign partial = {rem_q, num_q[lph_pkg::NUM_W-1]};
  assign diff    = {1'b0, partial} - {2'b00, wdiv};
  assign qbit    = ~diff[lph_pkg::WIN_W+1];
  assign rem_n   = qbit ? diff[lph_pkg::WIN_W-1:0] : partial[lph_pkg::WIN_W-1:0];

  assign lim  = neg_q ? (lph_pkg::QUO_W'(1) << (lph_pkg::DATA_W-1))
                      : (lph_pkg::QUO_W'(1) << (lph_pkg::DATA_W-1)) - 1'b1;
  assign over = big_q | (quo_q > lim);
  assign mag_fin = over ? lim[lph_pkg::DATA_W-1:0] : quo_q[lph_pkg::DATA_W-1:0];

  assign out_free = ~out_vld_q | out_ready_i;
  assign q_pop_o  = (state_q == ST_IDLE) & q_valid_i;

  assign out_valid_o   = out_vld_q;
  assign hash_value_o  = hash_q;
  assign saturated_o   = sat_q;
  assign count_error_o = cerr_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      s_q        <= '0;
      clamp_q    <= 1'b0;
      cerr_q     <= 1'b0;
      neg_q      <= 1'b0;
      mag_q      <= '0;
      num_q      <= '0;
      rem_q      <= '0;
      quo_q      <= '0;
      big_q      <= 1'b0;
      step_q     <= '0;
      out_vld_q  <= 1'b0;
      hash_q     <= '0;
      sat_q      <= 1'b0;
      cerr_out_q <= 1'b0;
    end else begin
      // in ST_FIN the output register is reloaded instead
      if (out_vld_q && out_ready_i && (state_q != ST_FIN)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            s_q     <= q_word_i.sum;
            clamp_q <= q_word_i.clamp;
            cerr_q  <= q_word_i.cerr;
            state_q <= ST_OFFS;
          end
        end
        ST_OFFS: begin
          s_q     <= offs_res[lph_pkg::ACC_W-1:0];
          clamp_q <= clamp_q | offs_res[lph_pkg::ACC_W];
          state_q <= ST_MAG;
        end
        ST_MAG: begin
          neg_q   <= s_q[lph_pkg::ACC_W-1];
          mag_q   <= s_q[lph_pkg::ACC_W-1] ? '0 - s_q : s_q;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          num_q   <= scaled[lph_pkg::ACC_W+lph_pkg::SCALE_W-1:lph_pkg::FRAC_W];
          rem_q   <= '0;
          quo_q   <= '0;
          big_q   <= 1'b0;
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= rem_n;
          num_q  <= {num_q[lph_pkg::NUM_W-2:0], 1'b0};
          quo_q  <= {quo_q[lph_pkg::QUO_W-2:0], qbit};
          big_q  <= big_q | quo_q[lph_pkg::QUO_W-1];
          step_q <= step_q + 1'b1;
          if (step_q == lph_pkg::STEP_W'(lph_pkg::NUM_W - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            hash_q     <= neg_q ? '0 - mag_fin : mag_fin;
            sat_q      <= clamp_q | over;
            cerr_out_q <= cerr_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/lsh_projection_hash.sv
// ----------------------------------------------------------------------------
// lsh_projection_hash
// Fixed-point p-stable LSH projection: dot product, offset, scale and divide.
// Throughput: one coordinate word per cycle while in_ready_o is high, which drops when
//   the queue has no room; the front takes words of the next point while the back part's
//   one-bit-per-cycle divider (55 steps) still works on an earlier one.
// Reset: rst_ni is asynchronous; clears the accumulator, queue and sequencer,
//   and loads dimension 1, offset 0, window 1.0.
// ----------------------------------------------------------------------------
module lsh_projection_hash (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [lph_pkg::DATA_W-1:0] coordinate_i,
  input  logic signed [lph_pkg::DATA_W-1:0] weight_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lph_pkg::DATA_W-1:0] hash_value_o,
  output logic                              saturated_o,
  output logic                              count_error_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lph_pkg::PADDR_W-1:0]       paddr,
  input  logic [lph_pkg::DATA_W-1:0]        pwdata,
  output logic [lph_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic [lph_pkg::DIM_W-1:0]         dim_q;
  logic signed [lph_pkg::DATA_W-1:0] offs_q;
  logic [lph_pkg::WIN_W-1:0]         win_q;
  lph_pkg::reg_addr_e                reg_sel;
  logic                              wr_en;

  logic                              q_push;
  logic                              q_pop;
  logic                              q_valid;
  lph_pkg::pt_word_t                 q_wr_word;
  lph_pkg::pt_word_t                 q_rd_word;
  logic [lph_pkg::QCNT_W-1:0]        q_count;

  assign pready  = 1'b1;
  assign reg_sel = lph_pkg::reg_addr_e'(paddr[lph_pkg::PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    case (reg_sel)
      lph_pkg::REG_DIMENSION: prdata = lph_pkg::DATA_W'(dim_q);
      lph_pkg::REG_OFFSET:    prdata = offs_q;
      lph_pkg::REG_WINDOW:    prdata = lph_pkg::DATA_W'(win_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= lph_pkg::DIM_W'(1);
      offs_q <= '0;
      win_q  <= lph_pkg::WIN_W'(1) << lph_pkg::FRAC_W;
    end else if (wr_en) begin
      case (reg_sel)
        lph_pkg::REG_DIMENSION: dim_q  <= pwdata[lph_pkg::DIM_W-1:0];
        lph_pkg::REG_OFFSET:    offs_q <= pwdata;
        lph_pkg::REG_WINDOW:    win_q  <= pwdata[lph_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  lph_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .coordinate_i (coordinate_i),
    .weight_i     (weight_i),
    .last_i       (last_i),
    .dimension_i  (dim_q),
    .q_count_i    (q_count),
    .q_push_o     (q_push),
    .q_word_o     (q_wr_word)
  );

  lph_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (q_wr_word),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .word_o  (q_rd_word),
    .count_o (q_count)
  );

  lph_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_word_i      (q_rd_word),
    .q_pop_o       (q_pop),
    .offset_i      (offs_q),
    .window_i      (win_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hash_value_o  (hash_value_o),
    .saturated_o   (saturated_o),
    .count_error_o (count_error_o)
  );

  // a finished point sum is never pushed into a full queue
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_count < lph_pkg::QCNT_W'(lph_pkg::QDEPTH)) || q_pop)
    else $error("point word pushed into full queue");

  // the back only pops a queue that holds a word
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a dimension beyond the supported maximum always flags the count
  a_bad_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (lph_pkg::CMP_W'(dim_q) > lph_pkg::CMP_W'(lph_pkg::MAX_DIM))
      |-> count_error_o)
    else $error("count error missing for oversized dimension");

endmodule
